// ----- hw/rtl/afr_pkg.sv -----
// Shared types, codes and constants for the addressed frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package afr_pkg;

   // Default frame buffer depth
   localparam int BUFFER_DEPTH_DEFAULT = 16;

   // Command codes on the request channel
   localparam logic [1:0] CMD_CHAR  = 2'd0;
   localparam logic [1:0] CMD_REARM = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Decoded operations carried through the queue
   localparam logic [1:0] OP_NOP   = 2'd0;
   localparam logic [1:0] OP_CHAR  = 2'd1;
   localparam logic [1:0] OP_REARM = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // Response status codes
   localparam logic [2:0] ST_IGNORED = 3'd0;
   localparam logic [2:0] ST_HEADER  = 3'd1;
   localparam logic [2:0] ST_STORED  = 3'd2;
   localparam logic [2:0] ST_OK      = 3'd3;
   localparam logic [2:0] ST_CSERR   = 3'd4;
   localparam logic [2:0] ST_REARM   = 3'd5;
   localparam logic [2:0] ST_READ    = 3'd6;

   // Node address after reset
   localparam logic [3:0] NODE_ADDRESS_RESET = 4'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
      logic       ninth_bit;
      logic [3:0] read_index;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       message_ready;
      logic [7:0] read_data;
      logic [7:0] running_sum;
   } rsp_type;

   // One queued item after classification
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
      logic       ninth_bit;
      logic [3:0] read_index;
   } queue_entry_type;

endpackage
`default_nettype wire

// ----- hw/rtl/afr_front.sv -----
// Front end: accepts request items, decodes the command and queues them.
`timescale 1ns / 1ps
`default_nettype none
module afr_front
   import afr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_type         req_data,
   output logic                 q_valid,
   output queue_entry_type      q_entry,
   input  wire logic            q_pop
);

   queue_entry_type entry_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   queue_entry_type push_entry;
   logic            push;

   // Classify the command
   always_comb begin
      push_entry.rx_byte    = req_data.rx_byte;
      push_entry.ninth_bit  = req_data.ninth_bit;
      push_entry.read_index = req_data.read_index;
      case (req_data.cmd)
         CMD_CHAR:  push_entry.op = OP_CHAR;
         CMD_REARM: push_entry.op = OP_REARM;
         CMD_READ:  push_entry.op = OP_READ;
         default:   push_entry.op = OP_NOP;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/afr_back.sv -----
// Back end: frame state machine, frame buffer, checksum and response register.
`timescale 1ns / 1ps
`default_nettype none
module afr_back
   import afr_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_valid,
   input  wire queue_entry_type q_entry,
   output logic                 q_pop,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [3:0]      csr_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_type              rsp_data
);

   localparam int AW = $clog2(BUFFER_DEPTH);

   logic [7:0]    frame_mem [BUFFER_DEPTH];

   logic [3:0]    node_address_ff;
   logic [4:0]    remaining_ff, remaining_in;
   logic [7:0]    sum_ff, sum_in;
   logic [4:0]    write_index_ff, write_index_in;
   logic          ready_ff, ready_in;
   logic          filter_ff, filter_in;

   logic          rsp_valid_ff;
   logic [2:0]    status_ff, status_in;
   logic          is_read_ff;
   logic [7:0]    mem_rd_ff;

   logic          wr_en;
   logic [4:0]    wr_addr;
   logic [4:0]    remaining_dec;

   assign csr_ready = 1'b1;
   assign q_pop     = q_valid && (!rsp_valid_ff || rsp_ready);

   // Execute one item against the frame state
   always_comb begin
      remaining_in   = remaining_ff;
      sum_in         = sum_ff;
      write_index_in = write_index_ff;
      ready_in       = ready_ff;
      filter_in      = filter_ff;
      status_in      = ST_IGNORED;
      wr_en          = 1'b0;
      wr_addr        = write_index_ff;
      remaining_dec  = remaining_ff - 5'd1;
      case (q_entry.op)
         OP_CHAR: begin
            if (filter_ff && !q_entry.ninth_bit) begin
               status_in = ST_IGNORED;
            end else if (remaining_ff != 5'd0) begin
               remaining_in = remaining_dec;
               if (remaining_dec == 5'd0) begin
                  if (sum_ff == q_entry.rx_byte) begin
                     ready_in  = 1'b1;
                     status_in = ST_OK;
                  end else begin
                     status_in = ST_CSERR;
                  end
               end else begin
                  // payload byte
                  sum_in    = sum_ff + q_entry.rx_byte;
                  wr_en     = (32'(write_index_ff) < BUFFER_DEPTH);
                  if (write_index_ff != 5'd31) begin
                     write_index_in = write_index_ff + 5'd1;
                  end
                  status_in = ST_STORED;
               end
            end else if (q_entry.rx_byte[3:0] != node_address_ff) begin
               status_in = ST_IGNORED;
            end else begin
               // header for this node: entry 0, length from high nibble
               filter_in      = 1'b0;
               remaining_in   = {1'b0, q_entry.rx_byte[7:4]} + 5'd1;
               sum_in         = q_entry.rx_byte;
               wr_en          = 1'b1;
               wr_addr        = 5'd0;
               write_index_in = 5'd1;
               status_in      = ST_HEADER;
            end
         end
         OP_REARM: begin
            ready_in     = 1'b0;
            filter_in    = 1'b1;
            remaining_in = 5'd0;
            status_in    = ST_REARM;
         end
         OP_READ: begin
            status_in = ST_READ;
         end
         default: begin
            status_in = ST_IGNORED;
         end
      endcase
   end

   // Control state and response handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff <= NODE_ADDRESS_RESET;
         remaining_ff    <= 5'd0;
         sum_ff          <= 8'd0;
         write_index_ff  <= 5'd0;
         ready_ff        <= 1'b0;
         filter_ff       <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            node_address_ff <= csr_data;
         end
         if (q_pop) begin
            remaining_ff   <= remaining_in;
            sum_ff         <= sum_in;
            write_index_ff <= write_index_in;
            ready_ff       <= ready_in;
            filter_ff      <= filter_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         status_ff  <= status_in;
         is_read_ff <= (q_entry.op == OP_READ);
      end
   end

   // Frame buffer: one write and one registered read per item
   always_ff @(posedge clock) begin
      if (q_pop && wr_en) begin
         frame_mem[wr_addr[AW-1:0]] <= q_entry.rx_byte;
      end
      if (q_pop) begin
         mem_rd_ff <= frame_mem[q_entry.read_index[AW-1:0]];
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.status        = status_ff;
   assign rsp_data.message_ready = ready_ff;
   assign rsp_data.read_data     = is_read_ff ? mem_rd_ff : 8'd0;
   assign rsp_data.running_sum   = sum_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/addressed_frame_receiver.sv -----
// Top level of the addressed frame receiver: front queue and back end.
//
// Usage:
//   req_* carries one item per handshake: a received 9-bit character
//   (cmd 0), a rearm (cmd 1) or a buffer read (cmd 2). Every item gives
//   exactly one rsp_* item with status, message_ready, read_data and the
//   running checksum. csr_* writes the 4-bit node address; it is always
//   ready and is meant to be written while the block is idle.
//   Path: an item waits in the decode queue; once popped, its response
//   is held in the back end's response register until it is taken.
//   Throughput: one item per cycle, set by the back end, unless a
//   response held by a low rsp_ready stalls it; the back end updates
//   the count, checksum and buffer write together and reads the
//   16-entry buffer through one registered port.
//   Reset: filtering on, no frame, checksum zero, node address 3; the
//   buffer contents are not cleared.
//   Stall: while rsp_ready is low the response register holds its item,
//   the two-entry queue fills, and req_ready drops once it is full.
`timescale 1ns / 1ps
`default_nettype none
module addressed_frame_receiver
   import afr_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [3:0] csr_data
);

   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;

   // Decode and queue
   afr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop)
   );

   // Frame processing
   afr_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
